// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the integer parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, switched off while reset is high.
`define AIP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("integer parser assertion failed");
// Checked property that also holds across reset.
`define AIP_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("integer parser reset assertion failed");
`else
`define AIP_ASSERT(lbl, clk, rst, prop)
`define AIP_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== src/aip_pkg.sv =====
// Types and constants shared by the integer parser modules.
package aip_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned PROD_W     = 70;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned OUT_TDATA_W = 80;

  localparam logic [RADIX_W-1:0] MAX_RADIX  = 6'd36;
  localparam logic [RADIX_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    PH_WS,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic               done;
    logic               bad;
    logic               ovf;
    logic [VALUE_W-1:0] accum;
    logic               inc;
  } digit_res_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               negative;
    logic [1:0]         status;
    logic [COUNT_W-1:0] consumed;
  } result_t;

endpackage

// ===== src/aip_in_reg.sv =====
// Input register that holds one character word for the parse stage.
module aip_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // ch
  input  logic          s_tlast,
  input  logic          adv,
  output logic          held,
  output aip_pkg::item_t item
);

  logic take;

  assign s_tready = !held || adv;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (adv) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.ch   <= s_tdata;
      item.last <= s_tlast;
    end
  end

endmodule

// ===== src/aip_digit.sv =====
// One digit step: classify a character and multiply-add it into the accumulator.
module aip_digit (
  input  logic [7:0]                    ch,
  input  logic [aip_pkg::RADIX_W-1:0]   base,
  input  logic [aip_pkg::VALUE_W-1:0]   accum,
  input  logic                          ovf,
  output aip_pkg::digit_res_t           res
);

  logic [7:0]                   d8;
  logic [aip_pkg::RADIX_W-1:0]  d;
  logic                         is_digit;
  logic [aip_pkg::PROD_W-1:0]   prod;

  always_comb begin
    d8       = 8'd0;
    is_digit = 1'b1;
    if (ch >= aip_pkg::CH_ZERO && ch <= aip_pkg::CH_NINE) begin
      d8 = ch - aip_pkg::CH_ZERO;
    end else if (ch >= aip_pkg::CH_LA && ch <= aip_pkg::CH_LZ) begin
      d8 = ch - aip_pkg::CH_LA + 8'd10;
    end else if (ch >= aip_pkg::CH_UA && ch <= aip_pkg::CH_UZ) begin
      d8 = ch - aip_pkg::CH_UA + 8'd10;
    end else begin
      is_digit = 1'b0;
    end
    d = d8[aip_pkg::RADIX_W-1:0];
  end

  // The 70-bit sum exceeds 64 bits exactly when the next digit would overflow the accumulator.
  assign prod = aip_pkg::PROD_W'(accum) * aip_pkg::PROD_W'(base) + aip_pkg::PROD_W'(d);

  always_comb begin
    res.done  = 1'b0;
    res.bad   = 1'b0;
    res.ovf   = ovf;
    res.accum = accum;
    res.inc   = 1'b0;
    if (ch == aip_pkg::CH_NUL) begin
      res.done = 1'b1;
    end else if (!is_digit || d >= base) begin
      res.done = 1'b1;
      res.bad  = 1'b1;
    end else begin
      res.inc = 1'b1;
      if (ovf || prod[aip_pkg::PROD_W-1:aip_pkg::VALUE_W] != '0) begin
        res.ovf = 1'b1;
      end else begin
        res.accum = prod[aip_pkg::VALUE_W-1:0];
      end
    end
  end

endmodule

// ===== src/aip_parse.sv =====
// Per-string parse state: whitespace, sign, prefix and digit phases.
module aip_parse #(
  parameter int unsigned MAX_LEN = 255
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [aip_pkg::RADIX_W-1:0] radix,
  input  logic                        adv,
  input  aip_pkg::item_t              item,
  output aip_pkg::result_t            result
);

  localparam int unsigned LIM = (MAX_LEN < 255) ? MAX_LEN : 255;
  localparam logic [aip_pkg::COUNT_W-1:0] CNT_LIM = aip_pkg::COUNT_W'(LIM);

  aip_pkg::phase_t phase, phase_next;
  logic [aip_pkg::VALUE_W-1:0] accum, accum_next;
  logic                        sign_neg, sign_neg_next;
  logic [aip_pkg::RADIX_W-1:0] cur_base, cur_base_next;
  logic                        ovf_flag, ovf_flag_next;
  logic                        bad_flag, bad_flag_next;
  logic [aip_pkg::COUNT_W-1:0] char_count, char_count_next;
  logic                        ended, ended_next;

  logic [aip_pkg::RADIX_W-1:0] eff_radix;
  logic [aip_pkg::RADIX_W-1:0] dig_base;
  logic                        is_ws, is_x, start_zero, use_dig, fin_zero;
  logic [1:0]                  inc;
  logic [aip_pkg::COUNT_W:0]   cnt_sum;
  logic [1:0]                  status;
  aip_pkg::digit_res_t         dig;

  assign eff_radix  = (radix > aip_pkg::MAX_RADIX) ? aip_pkg::MAX_RADIX : radix;
  assign is_ws      = (item.ch == aip_pkg::CH_SPACE) ||
                      (item.ch >= aip_pkg::CH_TAB && item.ch <= aip_pkg::CH_CR);
  assign is_x       = (item.ch == aip_pkg::CH_LX) || (item.ch == aip_pkg::CH_UX);
  assign start_zero = (item.ch == aip_pkg::CH_ZERO) &&
                      (eff_radix == aip_pkg::RADIX_AUTO || eff_radix == aip_pkg::BASE_HEX);

  always_comb begin
    case (phase)
      aip_pkg::PH_WS, aip_pkg::PH_SIGNED:
        dig_base = (eff_radix == aip_pkg::RADIX_AUTO) ? aip_pkg::BASE_DEC : eff_radix;
      aip_pkg::PH_ZERO:
        dig_base = (cur_base == aip_pkg::RADIX_AUTO) ? aip_pkg::BASE_OCT : cur_base;
      default:
        dig_base = cur_base;
    endcase
  end

  aip_digit u_digit (
    .ch    (item.ch),
    .base  (dig_base),
    .accum (accum),
    .ovf   (ovf_flag),
    .res   (dig)
  );

  always_comb begin
    phase_next = phase;
    if (!ended) begin
      case (phase)
        aip_pkg::PH_WS: begin
          if (is_ws) begin
            phase_next = aip_pkg::PH_WS;
          end else if (item.ch == aip_pkg::CH_MINUS || item.ch == aip_pkg::CH_PLUS) begin
            phase_next = aip_pkg::PH_SIGNED;
          end else if (start_zero) begin
            phase_next = aip_pkg::PH_ZERO;
          end else begin
            phase_next = aip_pkg::PH_DIGITS;
          end
        end
        aip_pkg::PH_SIGNED: begin
          phase_next = start_zero ? aip_pkg::PH_ZERO : aip_pkg::PH_DIGITS;
        end
        default: begin
          phase_next = aip_pkg::PH_DIGITS;
        end
      endcase
    end
  end

  always_comb begin
    sign_neg_next = sign_neg;
    cur_base_next = cur_base;
    ovf_flag_next = ovf_flag;
    bad_flag_next = bad_flag;
    accum_next    = accum;
    ended_next    = ended;
    inc           = 2'd0;
    use_dig       = 1'b0;
    if (!ended) begin
      case (phase)
        aip_pkg::PH_WS: begin
          if (is_ws || item.ch == aip_pkg::CH_PLUS) begin
            inc = 2'd1;
          end else if (item.ch == aip_pkg::CH_MINUS) begin
            sign_neg_next = 1'b1;
            inc           = 2'd1;
          end else if (start_zero) begin
            cur_base_next = eff_radix;
          end else begin
            cur_base_next = dig_base;
            use_dig       = 1'b1;
          end
        end
        aip_pkg::PH_SIGNED: begin
          if (start_zero) begin
            cur_base_next = eff_radix;
          end else begin
            cur_base_next = dig_base;
            use_dig       = 1'b1;
          end
        end
        aip_pkg::PH_ZERO: begin
          if (is_x) begin
            cur_base_next = aip_pkg::BASE_HEX;
            inc           = 2'd2;
          end else begin
            // The pending zero counts as a digit before this character.
            cur_base_next = dig_base;
            inc           = 2'd1;
            use_dig       = 1'b1;
          end
        end
        default: begin
          use_dig = 1'b1;
        end
      endcase
    end
    if (use_dig) begin
      ended_next    = dig.done;
      bad_flag_next = bad_flag | dig.bad;
      ovf_flag_next = dig.ovf;
      accum_next    = dig.accum;
      inc           = inc + {1'b0, dig.inc};
    end
    // A string that stops on the lone zero still counts that zero.
    fin_zero = item.last && !ended_next && (phase_next == aip_pkg::PH_ZERO);
    if (fin_zero) begin
      inc = inc + 2'd1;
    end
    cnt_sum = {1'b0, char_count} + (aip_pkg::COUNT_W + 1)'(inc);
    char_count_next = (cnt_sum > {1'b0, CNT_LIM}) ? CNT_LIM : cnt_sum[aip_pkg::COUNT_W-1:0];
  end

  always_comb begin
    status = ovf_flag_next ? aip_pkg::ST_RANGE :
             (bad_flag_next ? aip_pkg::ST_BAD : aip_pkg::ST_OK);
    result.value    = (status == aip_pkg::ST_OK) ? accum_next : '0;
    result.negative = sign_neg_next;
    result.status   = status;
    result.consumed = char_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (adv && item.last)) begin
      phase      <= aip_pkg::PH_WS;
      accum      <= '0;
      sign_neg   <= 1'b0;
      cur_base   <= '0;
      ovf_flag   <= 1'b0;
      bad_flag   <= 1'b0;
      char_count <= '0;
      ended      <= 1'b0;
    end else if (adv) begin
      phase      <= phase_next;
      accum      <= accum_next;
      sign_neg   <= sign_neg_next;
      cur_base   <= cur_base_next;
      ovf_flag   <= ovf_flag_next;
      bad_flag   <= bad_flag_next;
      char_count <= char_count_next;
      ended      <= ended_next;
    end
  end

endmodule

// ===== src/aip_out_reg.sv =====
// Result register that holds one finished word until the receiver takes it.
module aip_out_reg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  aip_pkg::result_t                    result,
  output logic                                free,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [aip_pkg::OUT_TDATA_W-1:0]     m_tdata  // value, negative, status, consumed
);

  aip_pkg::result_t held;

  assign free    = !m_tvalid || m_tready;
  assign m_tdata = {5'd0, held.consumed, held.status, held.negative, held.value};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// ===== src/ascii_integer_parser_core.sv =====
// Top level of the streaming ASCII to 64-bit unsigned integer parser.
// Characters enter on the s_ channel, one byte per word, and s_tlast marks
// the final character of a number string. The string's result leaves on the
// m_ channel as one word: magnitude, minus flag, status and consumed count.
// The base is set through cfg_we/cfg_wdata; zero selects automatic detection
// of octal, decimal or hexadecimal. Write it only while the block is idle.
// A character word is taken every cycle unless a last character waits for
// the output register to free. Each word is held in the input register and
// the parse stage does its whole digit step, a 64 by 6 bit multiply-add with
// the overflow test, combinationally; the output register then holds the result.
// While the receiver stalls, one finished result waits in the output
// register and characters of the next string keep flowing; the next last
// character holds in the input register until the output register frees.
// Reset clears the parse state, empties both registers and sets the base
// back to automatic detection.
`include "assert_macros.svh"
module ascii_integer_parser_core #(
  parameter int unsigned MAX_LEN = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ch
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // value[63:0], negative, status[1:0], consumed[7:0]
);

  localparam int unsigned LIM = (MAX_LEN < 255) ? MAX_LEN : 255;

  logic [aip_pkg::RADIX_W-1:0] radix;
  aip_pkg::item_t              item;
  aip_pkg::result_t            result;
  logic                        held;
  logic                        out_free;
  logic                        adv;
  logic                        out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= aip_pkg::RADIX_AUTO;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  assign adv      = held && (!item.last || out_free);
  assign out_load = adv && item.last;

  aip_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .adv      (adv),
    .held     (held),
    .item     (item)
  );

  aip_parse #(
    .MAX_LEN (MAX_LEN)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .radix  (radix),
    .adv    (adv),
    .item   (item),
    .result (result)
  );

  aip_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `AIP_ASSERT_NR(a_reset_empty, clk, rst |=> !m_tvalid)
  `AIP_ASSERT(a_result_from_last, clk, rst, $rose(m_tvalid) |-> $past(out_load))
  `AIP_ASSERT(a_error_zero_value, clk, rst, (m_tvalid && m_tdata[66:65] != aip_pkg::ST_OK) |-> (m_tdata[63:0] == 64'd0))
  `AIP_ASSERT(a_count_limit, clk, rst, m_tvalid |-> (m_tdata[74:67] <= 8'(LIM)))

endmodule
